// ===== sv/pass_pkg.sv =====
// Shared types and constants of the priority audio stream selector.
`default_nettype none

package pass_pkg;

	localparam int OP_W        = 3;
	localparam int IDX_FIELD_W = 3;
	localparam int COUNT_W     = 12;
	localparam int KIND_W      = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_PRIO_W  = 32;
	localparam int WAIT_MASK_W = 8;
	localparam int REG_INDEX_W = 1;

	localparam int MAX_NOTICES  = 4;
	localparam int NOTICE_PTR_W = 2;
	localparam int NOTICE_CNT_W = 3;

	localparam logic [REG_INDEX_W-1:0] REG_BRANCH_PRIORITIES = 1'd0;
	localparam logic [REG_INDEX_W-1:0] REG_FLUSH_WAIT_MASK   = 1'd1;

	localparam logic [WAIT_MASK_W-1:0] WAIT_MASK_RESET = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_WRITING  = 2'd1,
		ST_STOPPED  = 2'd2,
		ST_FLUSHING = 2'd3
	} stream_t;

	typedef enum logic [KIND_W-1:0] {
		K_WRITE_RET   = 3'd0,
		K_SINK_FLUSH  = 3'd1,
		K_SRC_RESUME  = 3'd2,
		K_SRC_FLUSHED = 3'd3,
		K_ACK         = 3'd4
	} notice_kind_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE         = 3'd0,
		OP_FLUSH         = 3'd1,
		OP_SINK_RESUME   = 3'd2,
		OP_SINK_FLUSHED  = 3'd3,
		OP_SELECT        = 3'd4,
		OP_AUTO_ON       = 3'd5,
		OP_AUTO_OFF      = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_CHECK,
		CS_SEARCH,
		CS_APPLY,
		CS_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic latch;
		logic search_clr;
		logic search_step;
		logic apply;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		logic need_search;
		logic search_last;
		logic notice_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/pass_if.sv =====
// Event and notice channel interfaces of the priority audio stream selector.
`default_nettype none

interface pass_event_if;
	import pass_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        op;
	logic [IDX_FIELD_W-1:0] branch_index;
	logic                   select_none;
	logic [COUNT_W-1:0]     sample_count;
	logic [COUNT_W-1:0]     sink_accept;

	modport source (
		output valid, op, branch_index, select_none, sample_count, sink_accept,
		input  ready
	);

	modport sink (
		input  valid, op, branch_index, select_none, sample_count, sink_accept,
		output ready
	);
endinterface

interface pass_notice_if;
	import pass_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      kind;
	logic [IDX_FIELD_W-1:0] target_branch;
	logic [COUNT_W-1:0]     value;
	logic [IDX_FIELD_W-1:0] selected_index;
	logic                   selected_valid;
	logic                   last;

	modport source (
		output valid, kind, target_branch, value, selected_index, selected_valid, last,
		input  ready
	);

	modport sink (
		input  valid, kind, target_branch, value, selected_index, selected_valid, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/priority_audio_stream_selector_core.sv =====
// Top level of the priority audio stream selector control plane.
//
// Events arrive on the events channel and notices leave on the notices
// channel; both use a valid/ready transfer. Configuration registers are
// written through write_enable, reg_index and write_data; the user must
// write them only while the block is idle, which the block does not
// enforce. Index 0 holds the packed branch priorities, index 1 the
// flush-wait mask. Each event yields one to four notices, the final one
// marked by last. Events are handled one at a time. After an event
// transfer the block decodes the event and then applies it, then offers
// its notices one per cycle while the receiver is ready. An event that
// has the selected branch flush without waiting, or lose auto-select,
// adds a priority scan between decoding and applying, one branch per
// cycle over all NUM_BRANCHES branches.
// Ready on the events channel is high only while the block is idle.
// When the receiver stalls, the current notice is held and no new event is
// taken. Reset clears all branch states, the selection, the output state and
// the configuration registers to their defaults.
`default_nettype none

module priority_audio_stream_selector_core #(
	parameter int NUM_BRANCHES = 8,
	parameter int PRIO_BITS    = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             write_enable,
	input  logic [pass_pkg::REG_INDEX_W-1:0] reg_index,
	input  logic [pass_pkg::CFG_DATA_W-1:0]  write_data,
	pass_event_if.sink                       events,
	pass_notice_if.source                    notices
);
	import pass_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pass_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (events.valid),
		.in_ready  (events.ready),
		.out_valid (notices.valid),
		.out_ready (notices.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pass_dp #(
		.NUM_BRANCHES (NUM_BRANCHES),
		.PRIO_BITS    (PRIO_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.write_enable   (write_enable),
		.reg_index      (reg_index),
		.write_data     (write_data),
		.op             (events.op),
		.branch_index   (events.branch_index),
		.select_none    (events.select_none),
		.sample_count   (events.sample_count),
		.sink_accept    (events.sink_accept),
		.kind           (notices.kind),
		.target_branch  (notices.target_branch),
		.value          (notices.value),
		.selected_index (notices.selected_index),
		.selected_valid (notices.selected_valid),
		.last           (notices.last)
	);

endmodule

`default_nettype wire

// ===== sv/pass_ctrl.sv =====
// Controller state machine that sequences event handling and notice delivery.
`default_nettype none

module pass_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  pass_pkg::dp_status_t status,
	output pass_pkg::dp_cmd_t    cmd
);
	import pass_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (in_valid) state_nx = CS_CHECK;
			end
			CS_CHECK: begin
				state_nx = status.need_search ? CS_SEARCH : CS_APPLY;
			end
			CS_SEARCH: begin
				if (status.search_last) state_nx = CS_APPLY;
			end
			CS_APPLY: begin
				state_nx = CS_EMIT;
			end
			CS_EMIT: begin
				if (out_ready && status.notice_last) state_nx = CS_IDLE;
			end
			default: begin
				state_nx = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = (state_q == CS_IDLE);
		out_valid       = (state_q == CS_EMIT);
		cmd.latch       = (state_q == CS_IDLE) && in_valid;
		cmd.search_clr  = (state_q == CS_CHECK);
		cmd.search_step = (state_q == CS_SEARCH);
		cmd.apply       = (state_q == CS_APPLY);
		cmd.pop         = (state_q == CS_EMIT) && out_ready;
	end

endmodule

`default_nettype wire

// ===== sv/pass_dp.sv =====
// Datapath holding the stream states, the selection, the priority search and the notice queue.
`default_nettype none

module pass_dp #(
	parameter int NUM_BRANCHES = 8,
	parameter int PRIO_BITS    = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pass_pkg::dp_cmd_t                    cmd,
	output pass_pkg::dp_status_t                 status,
	input  logic                                 write_enable,
	input  logic [pass_pkg::REG_INDEX_W-1:0]     reg_index,
	input  logic [pass_pkg::CFG_DATA_W-1:0]      write_data,
	input  logic [pass_pkg::OP_W-1:0]            op,
	input  logic [pass_pkg::IDX_FIELD_W-1:0]     branch_index,
	input  logic                                 select_none,
	input  logic [pass_pkg::COUNT_W-1:0]         sample_count,
	input  logic [pass_pkg::COUNT_W-1:0]         sink_accept,
	output logic [pass_pkg::KIND_W-1:0]          kind,
	output logic [pass_pkg::IDX_FIELD_W-1:0]     target_branch,
	output logic [pass_pkg::COUNT_W-1:0]         value,
	output logic [pass_pkg::IDX_FIELD_W-1:0]     selected_index,
	output logic                                 selected_valid,
	output logic                                 last
);
	import pass_pkg::*;

	localparam int IDX_W = $clog2(NUM_BRANCHES);

	typedef struct packed {
		stream_t      [NUM_BRANCHES-1:0]                 st;
		logic         [NUM_BRANCHES-1:0]                 au;
		logic                                            sv;
		logic         [IDX_W-1:0]                        si;
		stream_t                                         os;
		notice_kind_t [MAX_NOTICES-1:0]                  nk;
		logic         [MAX_NOTICES-1:0][IDX_FIELD_W-1:0] nt;
		logic         [MAX_NOTICES-1:0][COUNT_W-1:0]     nv;
		logic         [NOTICE_CNT_W-1:0]                 n;
	} ctx_t;

	// Configuration registers.
	logic [CFG_PRIO_W-1:0]  prio_cfg_q;
	logic [WAIT_MASK_W-1:0] wait_mask_q;

	// Event being handled.
	logic [OP_W-1:0]        op_q;
	logic [IDX_FIELD_W-1:0] b_q;
	logic                   none_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [COUNT_W-1:0]     acc_q;
	logic [PRIO_BITS-1:0]   prio_sel_q;
	logic [PRIO_BITS-1:0]   prio_b_q;

	// Selector state.
	stream_t [NUM_BRANCHES-1:0] st_q;
	logic    [NUM_BRANCHES-1:0] au_q;
	logic                       sv_q;
	logic    [IDX_W-1:0]        si_q;
	stream_t                    os_q;

	// Priority search.
	logic [IDX_W-1:0]     idx_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [PRIO_BITS-1:0] best_prio_q;

	// Notice queue.
	notice_kind_t [MAX_NOTICES-1:0]                  nk_q;
	logic         [MAX_NOTICES-1:0][IDX_FIELD_W-1:0] nt_q;
	logic         [MAX_NOTICES-1:0][COUNT_W-1:0]     nv_q;
	logic         [NOTICE_CNT_W-1:0]                 n_q;
	logic         [NOTICE_PTR_W-1:0]                 rd_q;

	logic [NUM_BRANCHES-1:0][PRIO_BITS-1:0] prio_of;
	logic [IDX_W-1:0]                       prio_addr;
	logic [PRIO_BITS-1:0]                   prio_rd;
	logic [IDX_W-1:0]                       bidx;
	logic                                   b_in;
	logic                                   needs_b;
	logic                                   ev_ok;
	logic                                   is_sel_b;
	logic                                   cand;
	ctx_t                                   nx;
	logic [COUNT_W-1:0]                     wr_ret;

	function automatic ctx_t f_emit(ctx_t c, notice_kind_t k, logic [IDX_FIELD_W-1:0] t,
			logic [COUNT_W-1:0] v);
		ctx_t r;
		r = c;
		if (r.n < NOTICE_CNT_W'(MAX_NOTICES)) begin
			r.nk[r.n[NOTICE_PTR_W-1:0]] = k;
			r.nt[r.n[NOTICE_PTR_W-1:0]] = t;
			r.nv[r.n[NOTICE_PTR_W-1:0]] = v;
			r.n = r.n + NOTICE_CNT_W'(1);
		end
		return r;
	endfunction

	function automatic ctx_t f_unselect(ctx_t c, logic [IDX_W-1:0] x);
		ctx_t r;
		r = c;
		if (r.st[x] == ST_STOPPED) begin
			r.st[x] = ST_WRITING;
			r = f_emit(r, K_SRC_RESUME, IDX_FIELD_W'(x), '0);
		end else if (r.st[x] == ST_FLUSHING) begin
			r.st[x] = ST_IDLE;
			r = f_emit(r, K_SRC_FLUSHED, IDX_FIELD_W'(x), '0);
		end
		return r;
	endfunction

	function automatic ctx_t f_select(ctx_t c, logic valid, logic [IDX_W-1:0] idx);
		ctx_t             r;
		logic             pv;
		logic [IDX_W-1:0] pi;
		r  = c;
		pv = r.sv;
		pi = r.si;
		if (!(valid == pv && (!valid || idx == pi))) begin
			r.sv = valid;
			r.si = valid ? idx : '0;
			if (pv) r = f_unselect(r, pi);
			if (r.os == ST_WRITING || r.os == ST_STOPPED) begin
				if (!valid || r.st[idx] == ST_IDLE) begin
					r.os = ST_FLUSHING;
					r = f_emit(r, K_SINK_FLUSH, '0, '0);
				end
			end
		end
		return r;
	endfunction

	function automatic ctx_t f_done(ctx_t c, logic [IDX_W-1:0] x);
		ctx_t r;
		r = c;
		if (r.st[x] == ST_FLUSHING) begin
			r.st[x] = ST_IDLE;
			if (r.au[x]) r = f_select(r, 1'b0, '0);
			r = f_emit(r, K_SRC_FLUSHED, IDX_FIELD_W'(x), '0);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_cfg_q  <= '0;
			wait_mask_q <= WAIT_MASK_RESET;
		end else if (write_enable) begin
			if (reg_index == REG_BRANCH_PRIORITIES) begin
				prio_cfg_q <= write_data[CFG_PRIO_W-1:0];
			end else if (reg_index == REG_FLUSH_WAIT_MASK) begin
				wait_mask_q <= write_data[WAIT_MASK_W-1:0];
			end
		end
	end

	// Branches whose field lies beyond the register have priority zero.
	for (genvar gi = 0; gi < NUM_BRANCHES; gi++) begin : g_prio
		localparam int SH = gi * PRIO_BITS;
		if (SH >= CFG_PRIO_W) begin : g_out
			assign prio_of[gi] = '0;
		end else begin : g_in
			logic [CFG_PRIO_W+PRIO_BITS-1:0] ext;
			assign ext         = {{PRIO_BITS{1'b0}}, prio_cfg_q};
			assign prio_of[gi] = ext[SH +: PRIO_BITS];
		end
	end

	assign bidx      = IDX_W'(b_q);
	assign prio_addr = cmd.latch ? si_q : (cmd.search_step ? idx_q : bidx);
	assign prio_rd   = prio_of[prio_addr];

	assign b_in     = (int'(b_q) < NUM_BRANCHES);
	assign needs_b  = (op_q == OP_WRITE) || (op_q == OP_FLUSH) || (op_q == OP_AUTO_ON)
			|| (op_q == OP_AUTO_OFF) || (op_q == OP_SELECT && !none_q);
	assign ev_ok    = !(needs_b && !b_in);
	assign is_sel_b = sv_q && (si_q == bidx);

	assign status.need_search = ev_ok && (
			(op_q == OP_FLUSH && (st_q[bidx] == ST_WRITING || st_q[bidx] == ST_STOPPED)
				&& is_sel_b && !wait_mask_q[b_q])
			|| (op_q == OP_AUTO_OFF && is_sel_b));
	assign status.search_last = (idx_q == IDX_W'(NUM_BRANCHES - 1));
	assign status.notice_last = ({1'b0, rd_q} + NOTICE_CNT_W'(1)) == n_q;

	// The branch of the event itself no longer qualifies once the event is applied.
	assign cand = au_q[idx_q] && (st_q[idx_q] == ST_WRITING || st_q[idx_q] == ST_STOPPED)
			&& (idx_q != bidx);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= op;
			b_q        <= branch_index;
			none_q     <= select_none;
			cnt_q      <= sample_count;
			acc_q      <= sink_accept;
			prio_sel_q <= prio_rd;
		end
		if (cmd.search_clr) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
			prio_b_q    <= prio_rd;
		end else if (cmd.search_step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (cand && (!found_q || prio_rd > best_prio_q)) begin
				found_q     <= 1'b1;
				best_q      <= idx_q;
				best_prio_q <= prio_rd;
			end
		end
		if (cmd.apply) begin
			nk_q <= nx.nk;
			nt_q <= nx.nt;
			nv_q <= nx.nv;
		end
	end

	always_comb begin
		nx    = '0;
		nx.st = st_q;
		nx.au = au_q;
		nx.sv = sv_q;
		nx.si = si_q;
		nx.os = os_q;
		wr_ret = cnt_q;
		if (ev_ok) begin
			unique case (op_q)
				OP_WRITE: begin
					nx.st[bidx] = ST_WRITING;
					if (nx.au[bidx] && !(nx.sv && nx.si == bidx)) begin
						if (!nx.sv || prio_sel_q < prio_b_q) nx = f_select(nx, 1'b1, bidx);
					end
					if (nx.sv && nx.si == bidx) begin
						nx.os  = ST_WRITING;
						wr_ret = (acc_q < cnt_q) ? acc_q : cnt_q;
						if (wr_ret == '0) begin
							nx.os       = ST_STOPPED;
							nx.st[bidx] = ST_STOPPED;
						end
					end
					nx = f_emit(nx, K_WRITE_RET, b_q, wr_ret);
				end
				OP_FLUSH: begin
					if (nx.st[bidx] == ST_IDLE) begin
						nx = f_emit(nx, K_SRC_FLUSHED, b_q, '0);
					end else if (nx.st[bidx] == ST_WRITING || nx.st[bidx] == ST_STOPPED) begin
						if (nx.sv && nx.si == bidx) begin
							nx.st[bidx] = ST_FLUSHING;
							if (!wait_mask_q[b_q] && found_q) nx = f_select(nx, 1'b1, best_q);
							if (nx.sv && nx.si == bidx) begin
								if (nx.os == ST_IDLE) begin
									nx = f_done(nx, bidx);
								end else if (nx.os != ST_FLUSHING) begin
									nx.os = ST_FLUSHING;
									nx = f_emit(nx, K_SINK_FLUSH, '0, '0);
								end
							end
						end else begin
							nx.st[bidx] = ST_IDLE;
							nx = f_emit(nx, K_SRC_FLUSHED, b_q, '0);
						end
					end
				end
				OP_SINK_RESUME: begin
					if (nx.os == ST_STOPPED) begin
						nx.os = ST_WRITING;
						if (nx.sv && nx.st[nx.si] == ST_STOPPED) begin
							nx.st[nx.si] = ST_WRITING;
							nx = f_emit(nx, K_SRC_RESUME, IDX_FIELD_W'(nx.si), '0);
						end
					end
				end
				OP_SINK_FLUSHED: begin
					if (nx.os == ST_FLUSHING) begin
						nx.os = ST_IDLE;
						if (nx.sv) nx = f_done(nx, nx.si);
					end
				end
				OP_SELECT: begin
					nx = f_select(nx, !none_q, none_q ? '0 : bidx);
				end
				OP_AUTO_ON: begin
					nx.au[bidx] = 1'b1;
				end
				OP_AUTO_OFF: begin
					nx.au[bidx] = 1'b0;
					if (nx.sv && nx.si == bidx) nx = f_select(nx, found_q, best_q);
				end
				default: begin
				end
			endcase
		end
		if (nx.n == '0) nx = f_emit(nx, K_ACK, '0, '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BRANCHES; i++) begin
				st_q[i] <= ST_IDLE;
			end
			au_q <= '0;
			sv_q <= 1'b0;
			si_q <= '0;
			os_q <= ST_IDLE;
			n_q  <= '0;
			rd_q <= '0;
		end else if (cmd.apply) begin
			st_q <= nx.st;
			au_q <= nx.au;
			sv_q <= nx.sv;
			si_q <= nx.si;
			os_q <= nx.os;
			n_q  <= nx.n;
			rd_q <= '0;
		end else if (cmd.pop) begin
			rd_q <= rd_q + NOTICE_PTR_W'(1);
		end
	end

	assign kind           = nk_q[rd_q];
	assign target_branch  = nt_q[rd_q];
	assign value          = nv_q[rd_q];
	assign selected_index = IDX_FIELD_W'(si_q);
	assign selected_valid = sv_q;
	assign last           = status.notice_last;

endmodule

`default_nettype wire
